>>> sv/utlw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar helpers for the UTC to local time block.
package utlw_pkg;

  localparam int EPOCH_YEAR = 2000;

  localparam logic [6:0] OFFSET_MAX   = 7'd104;
  localparam logic [6:0] OFFSET_RESET = 7'd48;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWELVE = 2'd1;

  localparam logic [4:0] FALLBACK_HOUR   = 5'd9;
  localparam logic [5:0] FALLBACK_MINUTE = 6'd41;

  typedef struct packed {
    logic        clock_ok;
    logic [11:0] utc_year;
    logic [3:0]  utc_month;
    logic [4:0]  utc_day;
    logic [4:0]  utc_hour;
    logic [5:0]  utc_minute;
  } item_t;

  typedef struct packed {
    logic [4:0] local_hour;
    logic [5:0] local_minute;
    logic       time_valid;
    logic [2:0] weekday;
    logic       weekday_valid;
  } result_t;

  // Day roll request from the minute arithmetic.
  typedef struct packed {
    logic back;
    logic fwd;
  } roll_t;

  // Gregorian leap test; divide by 100 as multiply by 5243 / 2^19 (exact below 4096).
  function automatic logic is_leap(input logic [11:0] y);
    logic [24:0] prod;
    logic [5:0]  cent;
    logic [11:0] rem;
    prod = {13'd0, y} * 25'd5243;
    cent = prod[24:19];
    rem  = y - ({6'd0, cent} * 12'd100);
    return (y[1:0] == 2'b00) && ((rem != 12'd0) || (cent[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month in a March-based year, reduced mod 7.
  function automatic logic [2:0] month_wday_offset(input logic [3:0] m);
    logic [2:0] off;
    case (m) inside
      4'd3, 4'd11: off = 3'd0;
      4'd2, 4'd6:  off = 3'd1;
      4'd9, 4'd12: off = 3'd2;
      4'd4, 4'd7:  off = 3'd3;
      4'd10:       off = 3'd4;
      4'd1, 4'd5:  off = 3'd5;
      4'd8:        off = 3'd6;
      default:     off = 3'd0;
    endcase
    return off;
  endfunction

  // Remainder by 7; quotient as multiply by 9363 / 2^16 (exact below 8192).
  function automatic logic [2:0] mod7(input logic [12:0] x);
    logic [26:0] prod;
    logic [10:0] quo;
    logic [12:0] rem;
    prod = {14'd0, x} * 27'd9363;
    quo  = prod[26:16];
    rem  = x - ({2'd0, quo} * 13'd7);
    return rem[2:0];
  endfunction

endpackage

>>> sv/utlw_wrap.sv
`timescale 1ns / 1ps
// Minute-of-day arithmetic: apply the quarter-hour offset and wrap into one day.
module utlw_wrap
  import utlw_pkg::*;
(
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [6:0]  offset,
  output logic [10:0] wrapped,
  output roll_t       roll
);

  // Offset register value 48 means zero; 48 quarters are 720 minutes.
  localparam logic [12:0] ZERO_MIN = 13'd720;
  localparam logic [12:0] DAY_END  = 13'd2160;

  logic [10:0] hm;
  logic [10:0] off15;
  logic [12:0] tsum;
  logic [12:0] w13;

  always_comb begin
    hm    = ({6'd0, hour} * 11'd60) + {5'd0, minute};
    off15 = {offset, 4'd0} - {4'd0, offset};
    tsum  = {2'd0, hm} + {2'd0, off15};
    roll.back = (tsum < ZERO_MIN);
    roll.fwd  = (tsum >= DAY_END);
    if (roll.back) begin
      w13 = tsum + ZERO_MIN;
    end else if (roll.fwd) begin
      w13 = tsum - DAY_END;
    end else begin
      w13 = tsum - ZERO_MIN;
    end
    wrapped = w13[10:0];
  end

endmodule

>>> sv/utlw_hm.sv
`timescale 1ns / 1ps
// Split minute of day into display hour and minute, 24-hour or 12-hour form.
module utlw_hm
  import utlw_pkg::*;
(
  input  logic [10:0] wrapped,
  input  logic        twelve,
  output logic [4:0]  hour,
  output logic [5:0]  minute
);

  logic [22:0] prod;
  logic [4:0]  h24;
  logic [4:0]  h12;
  logic [10:0] mins;

  always_comb begin
    // Divide by 60 as multiply by 2185 / 2^17, exact for a day's minutes.
    prod = {12'd0, wrapped} * 23'd2185;
    h24  = prod[21:17];
    mins = wrapped - ({6'd0, h24} * 11'd60);
    minute = mins[5:0];
    h12 = (h24 >= 5'd12) ? (h24 - 5'd12) : h24;
    if (h12 == 5'd0) begin
      h12 = 5'd12;
    end
    hour = twelve ? h12 : h24;
  end

endmodule

>>> sv/utlw_roll.sv
`timescale 1ns / 1ps
// Move a calendar date one day back or forward.
module utlw_roll
  import utlw_pkg::*;
(
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic        leap,
  input  roll_t       roll,
  output logic [12:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o
);

  logic [4:0] len_cur;
  logic [4:0] len_prev;

  always_comb begin
    len_cur  = month_len(month, leap);
    len_prev = month_len(month - 4'd1, leap);
    year_o   = {1'b0, year};
    month_o  = month;
    day_o    = day;
    if (roll.back) begin
      if (day > 5'd1) begin
        day_o = day - 5'd1;
      end else if (month > 4'd1) begin
        month_o = month - 4'd1;
        day_o   = len_prev;
      end else begin
        month_o = 4'd12;
        year_o  = {1'b0, year} - 13'd1;
        day_o   = 5'd31;
      end
    end else if (roll.fwd) begin
      if (day < len_cur) begin
        day_o = day + 5'd1;
      end else if (month < 4'd12) begin
        day_o   = 5'd1;
        month_o = month + 4'd1;
      end else begin
        day_o   = 5'd1;
        month_o = 4'd1;
        year_o  = {1'b0, year} + 13'd1;
      end
    end
  end

endmodule

>>> sv/utlw_dsum.sv
`timescale 1ns / 1ps
// Day-count sum whose remainder by 7 is the weekday.
module utlw_dsum
  import utlw_pkg::*;
(
  input  logic [12:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic [12:0] dsum
);

  // Epoch weekday shift minus one for day numbering, plus 6 weeks to keep the sum positive.
  localparam logic [12:0] WDAY_BIAS = 13'd44;

  logic [12:0] yy13;
  logic [11:0] yy;
  logic [24:0] prod;
  logic [5:0]  cent;

  always_comb begin
    // January and February count with the previous year. A year carried past 4095
    // only ever lands in January, so yy stays in 12 bits.
    yy13 = (month <= 4'd2) ? (year - 13'd1) : year;
    yy   = yy13[11:0];
    prod = {13'd0, yy} * 25'd5243;
    cent = prod[24:19];
    // 365 is 1 mod 7, so the year term reduces to yy itself.
    dsum = {1'b0, yy} + {3'd0, yy[11:2]} + {9'd0, cent[5:2]}
         + {10'd0, month_wday_offset(month)} + {8'd0, day} + WDAY_BIAS
         - {7'd0, cent};
  end

endmodule

>>> sv/utc_to_local_time_weekday.sv
`timescale 1ns / 1ps
// Top level: UTC reading to local time, 12/24-hour display and weekday.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+-------------------------------
//  input    | start, busy, item (item_t)           | word taken when start && !busy
//  config   | cfg_valid, cfg_ready, cfg_index/data | write when cfg_valid && cfg_ready
//  result   | done, result (result_t)              | word present for one cycle at done
//
// One word is taken every cycle; busy is never raised and cfg_ready is always high.
// Each word gives exactly one result; done rises as the result register loads it.
// The path is an input register, three pipeline stages and the result register; the
// weekday path (leap test, date roll, day-count sum, remainder by 7) sets that depth.
// Synchronous reset clears the pipeline valid flags and done and resets the config.
// The receiver has no stall; results stream out in input order.
module utc_to_local_time_weekday
  import utlw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]           cfg_data,
  output logic                 done,
  output result_t              result
);

  typedef struct packed {
    logic        ok;
    logic        date_ok;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    roll_t       roll;
    logic [10:0] wrapped;
  } s1_t;

  typedef struct packed {
    logic        ok;
    logic        date_ok;
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } s2_t;

  typedef struct packed {
    logic        ok;
    logic        date_ok;
    logic [12:0] dsum;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } s3_t;

  // Configuration registers.
  logic [6:0] utc_offset_quarters;
  logic       use_twelve_hour;

  // Pipeline.
  logic    s0_valid, s1_valid, s2_valid, s3_valid;
  item_t   s0;
  s1_t     s1, s1_next;
  s2_t     s2, s2_next;
  s3_t     s3, s3_next;
  result_t result_next;

  logic        accept;
  logic [10:0] wrapped;
  roll_t       roll;
  logic [12:0] r_year;
  logic [3:0]  r_month;
  logic [4:0]  r_day;
  logic [4:0]  hm_hour;
  logic [5:0]  hm_minute;
  logic [12:0] dsum;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Config writes: saturate the offset at its top value, ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      utc_offset_quarters <= OFFSET_RESET;
      use_twelve_hour     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET: utc_offset_quarters <= (cfg_data > OFFSET_MAX) ? OFFSET_MAX : cfg_data;
        CFG_TWELVE: use_twelve_hour <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: offset arithmetic, date check, leap test.
  utlw_wrap u_wrap (
    .hour    (s0.utc_hour),
    .minute  (s0.utc_minute),
    .offset  (utc_offset_quarters),
    .wrapped (wrapped),
    .roll    (roll)
  );

  always_comb begin
    s1_next.ok      = s0.clock_ok;
    s1_next.date_ok = (s0.utc_year >= 12'(EPOCH_YEAR)) && (s0.utc_month >= 4'd1)
                   && (s0.utc_month <= 4'd12) && (s0.utc_day != 5'd0);
    s1_next.year    = s0.utc_year;
    s1_next.month   = s0.utc_month;
    s1_next.day     = s0.utc_day;
    s1_next.leap    = is_leap(s0.utc_year);
    s1_next.roll    = roll;
    s1_next.wrapped = wrapped;
  end

  // Stage 2: roll the date, split hour and minute.
  utlw_roll u_roll (
    .year    (s1.year),
    .month   (s1.month),
    .day     (s1.day),
    .leap    (s1.leap),
    .roll    (s1.roll),
    .year_o  (r_year),
    .month_o (r_month),
    .day_o   (r_day)
  );

  utlw_hm u_hm (
    .wrapped (s1.wrapped),
    .twelve  (use_twelve_hour),
    .hour    (hm_hour),
    .minute  (hm_minute)
  );

  always_comb begin
    s2_next.ok      = s1.ok;
    s2_next.date_ok = s1.date_ok;
    s2_next.year    = r_year;
    s2_next.month   = r_month;
    s2_next.day     = r_day;
    s2_next.hour    = hm_hour;
    s2_next.minute  = hm_minute;
  end

  // Stage 3: day-count sum.
  utlw_dsum u_dsum (
    .year  (s2.year),
    .month (s2.month),
    .day   (s2.day),
    .dsum  (dsum)
  );

  always_comb begin
    s3_next.ok      = s2.ok;
    s3_next.date_ok = s2.date_ok;
    s3_next.dsum    = dsum;
    s3_next.hour    = s2.hour;
    s3_next.minute  = s2.minute;
  end

  // Result: reduce mod 7, substitute the fallback time when the clock was not read.
  always_comb begin
    if (s3.ok) begin
      result_next.local_hour    = s3.hour;
      result_next.local_minute  = s3.minute;
      result_next.time_valid    = 1'b1;
      result_next.weekday       = s3.date_ok ? mod7(s3.dsum) : 3'd0;
      result_next.weekday_valid = s3.date_ok;
    end else begin
      result_next.local_hour    = FALLBACK_HOUR;
      result_next.local_minute  = FALLBACK_MINUTE;
      result_next.time_valid    = 1'b0;
      result_next.weekday       = 3'd0;
      result_next.weekday_valid = 1'b0;
    end
  end

  // Advance valid flags every cycle; done follows the last stage's valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
  end

  // Payload registers: hold on an idle stage, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      s0 <= item;
    end
    if (s0_valid) begin
      s1 <= s1_next;
    end
    if (s1_valid) begin
      s2 <= s2_next;
    end
    if (s2_valid) begin
      s3 <= s3_next;
    end
    if (s3_valid) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("accepted word did not produce a result after five edges");

  a_fallback: assert property (@(posedge clk) disable iff (rst)
    (done && !result.time_valid) |-> (result.local_hour == FALLBACK_HOUR)
      && (result.local_minute == FALLBACK_MINUTE) && !result.weekday_valid
      && (result.weekday == 3'd0))
    else $error("fallback result malformed");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    (done && result.weekday_valid) |-> result.time_valid && (result.weekday != 3'd7))
    else $error("weekday out of range or valid without time");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    utc_offset_quarters <= OFFSET_MAX)
    else $error("offset register above saturation value");
`endif

endmodule
